### hw/rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, register map and clamp helper for the clamped-term PID block.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LIM_WIDTH  = WORD_WIDTH - 1;
    localparam int PROD_WIDTH = 2 * WORD_WIDTH;
    localparam int NUM_WIDTH  = PROD_WIDTH + 1;
    localparam int QUOT_WIDTH = WORD_WIDTH - 1;

    localparam int REG_COUNT  = 8;
    localparam int ADDR_WIDTH = $clog2(REG_COUNT) + 2;

    // register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_P_LIMIT   = 3'd3;
    localparam logic [2:0] REG_I_LIMIT   = 3'd4;
    localparam logic [2:0] REG_D_LIMIT   = 3'd5;
    localparam logic [2:0] REG_OUT_LIMIT = 3'd6;
    localparam logic [2:0] REG_JUMP_THR  = 3'd7;

    // 100.0 and 10.0 in Q16.16
    localparam logic [LIM_WIDTH-1:0] LIMIT_RESET = LIM_WIDTH'(100 << FRAC_BITS);
    localparam logic [LIM_WIDTH-1:0] JUMP_RESET  = LIM_WIDTH'(10 << FRAC_BITS);

    typedef struct packed {
        logic [WORD_WIDTH-1:0] gain_p;
        logic [WORD_WIDTH-1:0] gain_i;
        logic [WORD_WIDTH-1:0] gain_d;
        logic [LIM_WIDTH-1:0]  p_limit;
        logic [LIM_WIDTH-1:0]  i_limit;
        logic [LIM_WIDTH-1:0]  d_limit;
        logic [LIM_WIDTH-1:0]  out_limit;
        logic [LIM_WIDTH-1:0]  jump_threshold;
    } t_cfg;

    typedef struct packed {
        logic                  done;
        logic                  ovf;
        logic [QUOT_WIDTH-1:0] quot;
    } t_div_res;

    // Symmetric clamp on sign and magnitude: sign * min(mag, lim).
    function automatic logic [WORD_WIDTH-1:0] clamp_mag(
        input logic [PROD_WIDTH-1:0] mag,
        input logic                  neg,
        input logic [LIM_WIDTH-1:0]  lim
    );
        logic [LIM_WIDTH-1:0]  sel;
        logic [WORD_WIDTH-1:0] ext;
        begin
            sel = (mag > {{(PROD_WIDTH-LIM_WIDTH){1'b0}}, lim}) ? lim : mag[LIM_WIDTH-1:0];
            ext = {1'b0, sel};
            return neg ? (WORD_WIDTH'(0) - ext) : ext;
        end
    endfunction

endpackage

### hw/rtl/pct_regs.sv
// ----------------------------------------------------------------------------
// pct_regs
// APB-style register file holding gains, clamp limits and jump threshold.
// ----------------------------------------------------------------------------
module pct_regs
    import pct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.p_limit        <= LIMIT_RESET;
            r_cfg.i_limit        <= LIMIT_RESET;
            r_cfg.d_limit        <= LIMIT_RESET;
            r_cfg.out_limit      <= LIMIT_RESET;
            r_cfg.jump_threshold <= JUMP_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GAIN_P:    r_cfg.gain_p         <= pwdata;
                REG_GAIN_I:    r_cfg.gain_i         <= pwdata;
                REG_GAIN_D:    r_cfg.gain_d         <= pwdata;
                REG_P_LIMIT:   r_cfg.p_limit        <= pwdata[LIM_WIDTH-1:0];
                REG_I_LIMIT:   r_cfg.i_limit        <= pwdata[LIM_WIDTH-1:0];
                REG_D_LIMIT:   r_cfg.d_limit        <= pwdata[LIM_WIDTH-1:0];
                REG_OUT_LIMIT: r_cfg.out_limit      <= pwdata[LIM_WIDTH-1:0];
                REG_JUMP_THR:  r_cfg.jump_threshold <= pwdata[LIM_WIDTH-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAIN_P:    prdata = r_cfg.gain_p;
            REG_GAIN_I:    prdata = r_cfg.gain_i;
            REG_GAIN_D:    prdata = r_cfg.gain_d;
            REG_P_LIMIT:   prdata = {1'b0, r_cfg.p_limit};
            REG_I_LIMIT:   prdata = {1'b0, r_cfg.i_limit};
            REG_D_LIMIT:   prdata = {1'b0, r_cfg.d_limit};
            REG_OUT_LIMIT: prdata = {1'b0, r_cfg.out_limit};
            REG_JUMP_THR:  prdata = {1'b0, r_cfg.jump_threshold};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/pct_mul.sv
// ----------------------------------------------------------------------------
// pct_mul
// Shared unsigned 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module pct_mul
    import pct_pkg::*;
(
    input  logic                  i_clk,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic [PROD_WIDTH-1:0] o_prod
);

    logic [PROD_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_WIDTH'(i_a) * PROD_WIDTH'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/pct_div.sv
// ----------------------------------------------------------------------------
// pct_div
// Restoring serial divider, one quotient bit per cycle. Flags overflow when
// the quotient would reach 2^31, which lies beyond every clamp limit.
// ----------------------------------------------------------------------------
module pct_div
    import pct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_WIDTH-1:0]  i_num,
    input  logic [WORD_WIDTH-1:0] i_den,
    output t_div_res              o_res
);

    localparam int CNT_WIDTH = $clog2(QUOT_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_ovf;
    logic [CNT_WIDTH-1:0]  r_cnt;
    logic [WORD_WIDTH-1:0] r_rem;
    logic [WORD_WIDTH-1:0] r_den;
    logic [QUOT_WIDTH-1:0] r_bits;
    logic [QUOT_WIDTH-1:0] r_quot;

    logic [WORD_WIDTH:0]   trial;
    logic                  take;
    logic [WORD_WIDTH:0]   n_rem;
    logic                  start_ovf;

    assign trial     = {r_rem, r_bits[QUOT_WIDTH-1]};
    assign take      = trial >= {1'b0, r_den};
    assign n_rem     = take ? (trial - {1'b0, r_den}) : trial;
    assign start_ovf = i_num[NUM_WIDTH-1:QUOT_WIDTH]
                       >= {{(NUM_WIDTH-QUOT_WIDTH-WORD_WIDTH){1'b0}}, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf <= start_ovf;
                r_cnt <= CNT_WIDTH'(QUOT_WIDTH);
                if (start_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // partial remainder starts below the divisor, so 32 bits hold it
            r_rem  <= i_num[QUOT_WIDTH+WORD_WIDTH-1:QUOT_WIDTH];
            r_bits <= i_num[QUOT_WIDTH-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem[WORD_WIDTH-1:0];
            r_bits <= {r_bits[QUOT_WIDTH-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_WIDTH-2:0], take};
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;

endmodule

### hw/rtl/pid_controller_clamped_terms.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_terms
// Q16.16 PID step with per-term clamps, integral reset on setpoint jumps and
// a clamped drive sum, computed on one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_target, i_measured, i_dt
//  out     | output    | o_out_valid / i_out_stall  | o_drive, o_p_term, o_i_term,
//          |           |                            | o_d_term
//  cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// o_out_valid follows the input beat once the 31-step divider for the derivative is done (it is
// skipped when dt is zero and does not iterate when the quotient overflows); the rest is five
// multiplier passes and sums. o_in_stall stays high until the result loads, so a new input
// beat is taken only after the last result has loaded; a stalled result holds the next item in
// its final step. Reset is synchronous; gains clear, limits 100.0, threshold 10.0.
// ----------------------------------------------------------------------------
module pid_controller_clamped_terms
    import pct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [WORD_WIDTH-1:0] i_target,
    input  logic [WORD_WIDTH-1:0] i_measured,
    input  logic [WORD_WIDTH-1:0] i_dt,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WORD_WIDTH-1:0] o_drive,
    output logic [WORD_WIDTH-1:0] o_p_term,
    output logic [WORD_WIDTH-1:0] o_i_term,
    output logic [WORD_WIDTH-1:0] o_d_term,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERR    = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_MP     = 4'd3;
    localparam logic [3:0] S_MI     = 4'd4;
    localparam logic [3:0] S_MT0    = 4'd5;
    localparam logic [3:0] S_MT1    = 4'd6;
    localparam logic [3:0] S_MD0    = 4'd7;
    localparam logic [3:0] S_MD1    = 4'd8;
    localparam logic [3:0] S_DSTART = 4'd9;
    localparam logic [3:0] S_DWAIT  = 4'd10;
    localparam logic [3:0] S_SUM    = 4'd11;

    localparam int W = WORD_WIDTH;
    localparam int F = FRAC_BITS;

    t_cfg     cfg;
    t_div_res div_res;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // item operands
    logic [W-1:0] r_target;
    logic [W-1:0] r_measured;
    logic [W-1:0] r_dt;

    // step-to-step state
    logic [W-1:0] r_last_target;
    logic [W:0]   r_last_error;
    logic [W-1:0] r_acc;

    // working registers
    logic [W:0]            r_err;
    logic [W-1:0]          r_err_mag;
    logic                  r_err_neg;
    logic [W:0]            r_diff_mag;
    logic                  r_diff_neg;
    logic [W-1:0]          r_p;
    logic [W-1:0]          r_d;
    logic                  r_t1_neg;
    logic [W-F-1:0]        r_t1_hi;
    logic [PROD_WIDTH-1:0] r_lo;
    logic [W+2:0]          r_inc;
    logic [NUM_WIDTH-1:0]  r_num;

    // result register
    logic         r_out_valid;
    logic [W-1:0] r_drive;
    logic [W-1:0] r_p_out;
    logic [W-1:0] r_i_out;
    logic [W-1:0] r_d_out;

    // shared multiplier
    logic [W-1:0]          mul_a;
    logic [W-1:0]          mul_b;
    logic [PROD_WIDTH-1:0] prod;

    logic         gp_neg, gi_neg, gd_neg;
    logic [W-1:0] gp_mag, gi_mag, gd_mag;

    logic         in_accept;
    logic         out_load;
    logic         div_start;

    logic [W:0]     jump_diff;
    logic [W:0]     jump_mag;
    logic           jump;
    logic [W:0]     err_next;
    logic [W:0]     err_abs;
    logic [W+1:0]   diff;
    logic [W+1:0]   diff_abs;
    logic [W+F+W-1:0] inc_full;
    logic [PROD_WIDTH-1:0] inc_mag;
    logic [W+1:0]   inc_sat;
    logic [W+3:0]   acc_sum;
    logic [W+3:0]   acc_abs;
    logic [NUM_WIDTH-1:0] num_next;
    logic [PROD_WIDTH-1:0] d_mag;
    logic [W+1:0]   drive_sum;
    logic [W+1:0]   drive_abs;

    pct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    pct_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_dt),
        .o_res   (div_res)
    );

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_SUM) && (!r_out_valid || !i_out_stall);
    assign div_start   = (r_state == S_DSTART) && (r_dt != '0);

    assign gp_neg = cfg.gain_p[W-1];
    assign gi_neg = cfg.gain_i[W-1];
    assign gd_neg = cfg.gain_d[W-1];
    assign gp_mag = gp_neg ? (W'(0) - cfg.gain_p) : cfg.gain_p;
    assign gi_mag = gi_neg ? (W'(0) - cfg.gain_i) : cfg.gain_i;
    assign gd_mag = gd_neg ? (W'(0) - cfg.gain_d) : cfg.gain_d;

    // setpoint jump and error
    assign jump_diff = {r_last_target[W-1], r_last_target} - {r_target[W-1], r_target};
    assign jump_mag  = jump_diff[W] ? ((W+1)'(0) - jump_diff) : jump_diff;
    assign jump      = jump_mag > {2'b00, cfg.jump_threshold};
    assign err_next  = {r_target[W-1], r_target} - {r_measured[W-1], r_measured};

    // error magnitude and error change
    assign err_abs  = r_err[W] ? ((W+1)'(0) - r_err) : r_err;
    assign diff     = {r_err[W], r_err} - {r_last_error[W], r_last_error};
    assign diff_abs = diff[W+1] ? ((W+2)'(0) - diff) : diff;

    // integral increment: (t1 low word * dt) + (t1 high part * dt) << 32
    assign inc_full = {{(W+F+W-PROD_WIDTH){1'b0}}, r_lo}
                      + {prod[W+F-1:0], {W{1'b0}}};
    assign inc_mag  = inc_full[W+F+W-1:F];
    // anything at 2^33 or above clamps the same way as the true value
    assign inc_sat  = (|inc_mag[PROD_WIDTH-1:W+1]) ? {1'b1, {(W+1){1'b0}}}
                                                   : {1'b0, inc_mag[W:0]};

    assign acc_sum = {{4{r_acc[W-1]}}, r_acc} + {r_inc[W+2], r_inc};
    assign acc_abs = acc_sum[W+3] ? ((W+4)'(0) - acc_sum) : acc_sum;

    assign num_next = {1'b0, prod}
                      + (r_diff_mag[W] ? {1'b0, gd_mag, {W{1'b0}}} : NUM_WIDTH'(0));

    assign d_mag = div_res.ovf ? {{(PROD_WIDTH-W){1'b0}}, 1'b1, {(W-1){1'b0}}}
                               : {{(PROD_WIDTH-QUOT_WIDTH){1'b0}}, div_res.quot};

    assign drive_sum = {{2{r_p[W-1]}}, r_p} + {{2{r_acc[W-1]}}, r_acc}
                       + {{2{r_d[W-1]}}, r_d};
    assign drive_abs = drive_sum[W+1] ? ((W+2)'(0) - drive_sum) : drive_sum;

    // multiplier operand select per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MP: begin
                mul_a = gp_mag;
                mul_b = r_err_mag;
            end
            S_MI: begin
                mul_a = gi_mag;
                mul_b = r_err_mag;
            end
            S_MT0: begin
                mul_a = prod[W+F-1:F];
                mul_b = r_dt;
            end
            S_MT1: begin
                mul_a = {{F{1'b0}}, r_t1_hi};
                mul_b = r_dt;
            end
            S_MD0: begin
                mul_a = gd_mag;
                mul_b = r_diff_mag[W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_accept) n_state = S_ERR;
            S_ERR:    n_state = S_DIFF;
            S_DIFF:   n_state = S_MP;
            S_MP:     n_state = S_MI;
            S_MI:     n_state = S_MT0;
            S_MT0:    n_state = S_MT1;
            S_MT1:    n_state = S_MD0;
            S_MD0:    n_state = S_MD1;
            S_MD1:    n_state = S_DSTART;
            S_DSTART: n_state = (r_dt == '0) ? S_SUM : S_DWAIT;
            S_DWAIT:  if (div_res.done) n_state = S_SUM;
            S_SUM:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_last_target <= '0;
            r_last_error  <= '0;
            r_acc         <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ERR) begin
                r_last_target <= r_target;
                if (jump) begin
                    r_acc <= '0;
                end
            end
            if (r_state == S_DIFF) begin
                r_last_error <= r_err;
            end
            if (r_state == S_MD1) begin
                r_acc <= clamp_mag({{(PROD_WIDTH-W-4){1'b0}}, acc_abs},
                                   acc_sum[W+3], cfg.i_limit);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_target   <= i_target;
            r_measured <= i_measured;
            r_dt       <= i_dt;
        end
        unique case (r_state)
            S_ERR: begin
                r_err <= err_next;
            end
            S_DIFF: begin
                r_err_mag  <= err_abs[W-1:0];
                r_err_neg  <= r_err[W];
                r_diff_mag <= diff_abs[W:0];
                r_diff_neg <= diff[W+1];
            end
            S_MI: begin
                r_p <= clamp_mag({{F{1'b0}}, prod[PROD_WIDTH-1:F]},
                                 gp_neg ^ r_err_neg, cfg.p_limit);
            end
            S_MT0: begin
                r_t1_hi  <= prod[PROD_WIDTH-1:W+F];
                r_t1_neg <= gi_neg ^ r_err_neg;
            end
            S_MT1: begin
                r_lo <= prod;
            end
            S_MD0: begin
                r_inc <= r_t1_neg ? ((W+3)'(0) - {1'b0, inc_sat}) : {1'b0, inc_sat};
            end
            S_MD1: begin
                r_num <= num_next;
            end
            S_DSTART: begin
                if (r_dt == '0) begin
                    r_d <= '0;
                end
            end
            S_DWAIT: begin
                if (div_res.done) begin
                    r_d <= clamp_mag(d_mag, gd_neg ^ r_diff_neg, cfg.d_limit);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_drive <= clamp_mag({{(PROD_WIDTH-W-2){1'b0}}, drive_abs},
                                 drive_sum[W+1], cfg.out_limit);
            r_p_out <= r_p;
            r_i_out <= r_acc;
            r_d_out <= r_d;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_p_term    = r_p_out;
    assign o_i_term    = r_i_out;
    assign o_d_term    = r_d_out;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait step");

    a_jump_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR && jump) |=> (r_acc == '0))
        else $error("integral not cleared after setpoint jump");

    a_zero_dt_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTART && r_dt == '0) |=> (r_state == S_SUM && r_d == '0))
        else $error("zero elapsed time did not bypass the divider");

    a_result_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SUM))
        else $error("result beat raised outside the sum step");

endmodule

### bench/pid_controller_clamped_terms_tb.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_terms_tb
// Drives the clamped-term PID block with directed corner cases, then with
// long random runs of setpoint tracking and noise under several register
// settings. A scoreboard predicts every drive beat and compares all fields.
// ----------------------------------------------------------------------------
module pid_controller_clamped_terms_tb
    import pct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES   = 7;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_TAIL     = 60;
    localparam int          RANDOM_PHASES  = 9;
    localparam int          PHASE_ITEMS    = 150;
    localparam logic [127:0] SAT_MAG       = 128'd1 << 62;

    // Q16.16 constants used by the stimulus
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    localparam logic [31:0] DIR_TARGET [8] = '{
        32'h0000_0000, 32'h000A_0000, 32'h0014_0001, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0000, 32'hFFFB_0000, 32'h0000_0001
    };
    localparam logic [31:0] DIR_MEASURED [8] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000, 32'hFFFF_FFFF
    };
    localparam logic [31:0] DIR_DT [8] = '{
        32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h0000_0000, 32'h0001_0000, 32'h0000_0001
    };

    typedef struct packed {
        logic [WORD_WIDTH-1:0] drive;
        logic [WORD_WIDTH-1:0] p_term;
        logic [WORD_WIDTH-1:0] i_term;
        logic [WORD_WIDTH-1:0] d_term;
    } t_drive_beat;

    class drive_scoreboard;
        logic signed [WORD_WIDTH-1:0] gain_p, gain_i, gain_d;
        logic [LIM_WIDTH-1:0]         p_limit, i_limit, d_limit, out_limit, jump_thr;
        longint                       integral, last_err, prev_target;
        t_drive_beat                  expected_drives[$];
        int                           errors, samples, results;
        int                           integral_clears, zero_dt_steps;

        function new();
            gain_p          = '0;
            gain_i          = '0;
            gain_d          = '0;
            p_limit         = LIM_WIDTH'(100 << FRAC_BITS);
            i_limit         = LIM_WIDTH'(100 << FRAC_BITS);
            d_limit         = LIM_WIDTH'(100 << FRAC_BITS);
            out_limit       = LIM_WIDTH'(100 << FRAC_BITS);
            jump_thr        = LIM_WIDTH'(10 << FRAC_BITS);
            integral        = 0;
            last_err        = 0;
            prev_target     = 0;
            errors          = 0;
            samples         = 0;
            results         = 0;
            integral_clears = 0;
            zero_dt_steps   = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_GAIN_P:    gain_p    = value;
                REG_GAIN_I:    gain_i    = value;
                REG_GAIN_D:    gain_d    = value;
                REG_P_LIMIT:   p_limit   = value[LIM_WIDTH-1:0];
                REG_I_LIMIT:   i_limit   = value[LIM_WIDTH-1:0];
                REG_D_LIMIT:   d_limit   = value[LIM_WIDTH-1:0];
                REG_OUT_LIMIT: out_limit = value[LIM_WIDTH-1:0];
                REG_JUMP_THR:  jump_thr  = value[LIM_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // Fractional multiply on magnitudes, truncated, saturated at 2^62.
        function longint scale_q(longint a, longint b);
            logic [63:0]  ma, mb, mag;
            logic [127:0] prod;
            ma   = (a < 0) ? -a : a;
            mb   = (b < 0) ? -b : b;
            prod = ({64'd0, ma} * {64'd0, mb}) >> FRAC_BITS;
            mag  = (prod > SAT_MAG) ? SAT_MAG[63:0] : prod[63:0];
            return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
        endfunction

        function longint limit_sym(longint v, logic [LIM_WIDTH-1:0] lim);
            longint l;
            l = longint'(lim);
            if (v > l)
                return l;
            if (v < -l)
                return -l;
            return v;
        endfunction

        function t_drive_beat predict_drive(logic signed [WORD_WIDTH-1:0] tgt_in,
                                            logic signed [WORD_WIDTH-1:0] meas_in,
                                            logic [WORD_WIDTH-1:0] dt_in);
            longint       tgt, err, jump, delta, p, inc, acc, d, total;
            logic [63:0]  mg, me, dmag;
            logic [127:0] quot;
            t_drive_beat  beat;
            tgt  = tgt_in;
            jump = prev_target - tgt;
            if (jump < 0)
                jump = -jump;
            if (jump > longint'(jump_thr)) begin
                integral = 0;
                integral_clears++;
            end
            prev_target = tgt;
            err = tgt - longint'(meas_in);

            p        = limit_sym(scale_q(longint'(gain_p), err), p_limit);
            inc      = scale_q(scale_q(longint'(gain_i), err), longint'(dt_in));
            acc      = limit_sym(integral + inc, i_limit);
            integral = acc;

            if (dt_in == '0) begin
                d = 0;
                zero_dt_steps++;
            end else begin
                delta = err - last_err;
                mg    = (gain_d < 0) ? -longint'(gain_d) : longint'(gain_d);
                me    = (delta < 0) ? -delta : delta;
                quot  = ({64'd0, mg} * {64'd0, me}) / {96'd0, dt_in};
                dmag  = (quot > SAT_MAG) ? SAT_MAG[63:0] : quot[63:0];
                d     = ((gain_d < 0) != (delta < 0)) ? -longint'(dmag) : longint'(dmag);
                d     = limit_sym(d, d_limit);
            end
            last_err = err;

            total       = limit_sym(p + acc + d, out_limit);
            beat.drive  = total[WORD_WIDTH-1:0];
            beat.p_term = p[WORD_WIDTH-1:0];
            beat.i_term = acc[WORD_WIDTH-1:0];
            beat.d_term = d[WORD_WIDTH-1:0];
            return beat;
        endfunction

        function void note_sample(logic [WORD_WIDTH-1:0] tgt_in, logic [WORD_WIDTH-1:0] meas_in,
                                  logic [WORD_WIDTH-1:0] dt_in);
            expected_drives.push_back(predict_drive(tgt_in, meas_in, dt_in));
            samples++;
        endfunction

        function void compare_field(string name, logic [WORD_WIDTH-1:0] want,
                                    logic [WORD_WIDTH-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d (0x%h), got %0d (0x%h)",
                       name, signed'(want), want, signed'(got), got);
                errors++;
            end
        endfunction

        function void check_drive(t_drive_beat got);
            t_drive_beat want;
            if (expected_drives.size() == 0) begin
                $error("result beat with no sample pending: drive 0x%h", got.drive);
                errors++;
                return;
            end
            want = expected_drives.pop_front();
            results++;
            compare_field("drive",  want.drive,  got.drive);
            compare_field("p_term", want.p_term, got.p_term);
            compare_field("i_term", want.i_term, got.i_term);
            compare_field("d_term", want.d_term, got.d_term);
        endfunction

        function int pending_count();
            return expected_drives.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [WORD_WIDTH-1:0] i_target;
    logic [WORD_WIDTH-1:0] i_measured;
    logic [WORD_WIDTH-1:0] i_dt;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [WORD_WIDTH-1:0] o_drive;
    logic [WORD_WIDTH-1:0] o_p_term;
    logic [WORD_WIDTH-1:0] o_i_term;
    logic [WORD_WIDTH-1:0] o_d_term;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    drive_scoreboard       sb;
    int                    hold_asks;
    int                    hold_served;
    int                    idle_cycles = 0;
    int                    settings_used;
    logic [31:0]           track_target;
    logic [31:0]           cur_thr;

    pid_controller_clamped_terms u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_target    (i_target),
        .i_measured  (i_measured),
        .i_dt        (i_dt),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .o_p_term    (o_p_term),
        .o_i_term    (o_i_term),
        .o_d_term    (o_d_term),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Beat monitor and watchdog; both read pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0)
                sb.note_sample(i_target, i_measured, i_dt);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0)
                sb.check_drive(t_drive_beat'{o_drive, o_p_term, o_i_term, o_d_term});
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("pid_controller_clamped_terms_tb: FAIL");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with a long hold whenever one is asked for.
    initial begin : out_stall_gen
        int mode;
        int span;
        int tick;
        i_out_stall = 1'b0;
        hold_served = 0;
        tick        = 0;
        forever begin
            if (hold_served < hold_asks) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_served++;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 80);
                repeat (span) begin
                    @(negedge i_clk);
                    tick++;
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 99) < 30);
                        2: i_out_stall <= ($urandom_range(0, 99) < 85);
                        default: i_out_stall <= (tick % 5 != 0);
                    endcase
                end
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                               logic [31:0] pl, logic [31:0] il, logic [31:0] dl,
                               logic [31:0] ol, logic [31:0] jt);
        apb_write(REG_GAIN_P, gp);
        apb_write(REG_GAIN_I, gi);
        apb_write(REG_GAIN_D, gd);
        apb_write(REG_P_LIMIT, pl);
        apb_write(REG_I_LIMIT, il);
        apb_write(REG_D_LIMIT, dl);
        apb_write(REG_OUT_LIMIT, ol);
        apb_write(REG_JUMP_THR, jt);
        cur_thr = {1'b0, jt[LIM_WIDTH-1:0]};
        settings_used++;
    endtask

    task automatic send_beat(logic [31:0] tgt, logic [31:0] meas, logic [31:0] dt);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_target   <= tgt;
        i_measured <= meas;
        i_dt       <= dt;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Let every expected beat arrive, then settle before touching registers.
    task automatic wait_drained();
        idle_gap(1);
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] signed_span(int unsigned mag_max);
        logic [31:0] v;
        v = $urandom_range(0, mag_max);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return '0;
            default: return signed_span(8 << FRAC_BITS);
        endcase
    endfunction

    // Bit 31 is random on purpose: the limits keep only 31 bits.
    function automatic logic [31:0] rand_limit();
        logic [31:0] top;
        top = {$urandom_range(0, 1) == 1, 31'd0};
        case ($urandom_range(0, 5))
            0: return top;
            1: return top | 32'h7FFF_FFFF;
            2: return $urandom;
            default: return top | $urandom_range(0, 200 << FRAC_BITS);
        endcase
    endfunction

    task automatic run_directed();
        for (int k = 0; k < 8; k++) begin
            idle_gap($urandom_range(0, 2));
            send_beat(DIR_TARGET[k], DIR_MEASURED[k], DIR_DT[k]);
        end
        wait_drained();
    endtask

    task automatic run_random(int count, bit hold_midway);
        int          burst;
        logic [31:0] tgt, meas, dt;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            end
            burst--;
            if (hold_midway && k == count / 3)
                hold_asks++;
            if ($urandom_range(0, 99) < 25) begin
                // noise: every field fully random
                tgt  = $urandom;
                meas = $urandom;
                dt   = $urandom;
            end else begin
                case ($urandom_range(0, 9))
                    6, 7:    track_target = track_target + signed_span(30 << FRAC_BITS);
                    8:       track_target = track_target +
                                            (($urandom_range(0, 1) == 1) ? cur_thr : -cur_thr);
                    9:       track_target = track_target + cur_thr + 32'd1;
                    default: track_target = track_target + signed_span(ONE_Q);
                endcase
                tgt  = track_target;
                meas = tgt + signed_span(5 << FRAC_BITS);
                case ($urandom_range(0, 9))
                    0:       dt = '0;
                    1:       dt = $urandom;
                    default: dt = $urandom_range(1 << 10, 2 << FRAC_BITS);
                endcase
            end
            send_beat(tgt, meas, dt);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        logic [31:0] thr;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_target      = '0;
        i_measured    = '0;
        i_dt          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_asks     = 0;
        settings_used = 1;
        track_target  = '0;
        cur_thr       = 32'(10 << FRAC_BITS);
        sb            = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Gains only: limits and threshold stay at their reset values.
        apb_write(REG_GAIN_P, 32'h0002_0000);
        apb_write(REG_GAIN_I, 32'h0001_8000);
        apb_write(REG_GAIN_D, 32'hFFFF_4000);
        run_directed();

        // Zero limits force every term to zero; threshold zero clears on any move.
        load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        run_directed();

        load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF);
        run_directed();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            thr = ($urandom_range(0, 4) == 0) ? rand_limit()
                                              : $urandom_range(0, 20 << FRAC_BITS);
            load_config(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                        rand_limit(), rand_limit(), rand_limit(), thr);
            run_random(PHASE_ITEMS, ph == 3);
        end

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.pending_count() != 0) begin
            $error("%0d expected beats never arrived", sb.pending_count());
            sb.errors++;
        end
        $display("covered %0d samples under %0d register settings, %0d results checked",
                 sb.samples, settings_used, sb.results);
        $display("integral cleared %0d times, %0d steps with zero elapsed time",
                 sb.integral_clears, sb.zero_dt_steps);
        if (sb.errors == 0)
            $display("pid_controller_clamped_terms_tb: PASS");
        else
            $display("pid_controller_clamped_terms_tb: FAIL");
        $finish;
    end

endmodule
